FILE: src/btgw_pkg.sv
// btgw_pkg: shared types and constants for the beacon transmit guard block.
// No dependencies; used by btgw_ctrl, btgw_dp and beacon_tx_guard_window.
`default_nettype none

package btgw_pkg;

  localparam int TIME_W  = 32;
  localparam int MISS_W  = 8;
  localparam int OUT_W   = 48;  // 42 payload bits padded to whole bytes
  localparam int ADDR_W  = 4;
  localparam int CFG_W   = 32;

  // request kind carried on s_tuser
  localparam logic REQ_BEACON = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // register index, paddr[3:2]
  localparam logic [1:0] REG_PERIOD = 2'd0;
  localparam logic [1:0] REG_GUARD  = 2'd1;
  localparam logic [1:0] REG_OCC    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WINDOW,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // take the input word
    logic step;    // one catch-up compare/step
    logic window;  // final guard window compare
    logic emit;    // move result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic locked;    // current lock flag
    logic after;     // query lies past the predicted window end
    logic limit;     // miss count has reached the limit
    logic out_free;  // output register can take a word this cycle
  } status_t;

endpackage

`default_nettype wire

FILE: src/btgw_ctrl.sv
// btgw_ctrl: sequencer for one word at a time (accept, catch-up, window, emit).
// Depends on btgw_pkg.
`default_nettype none

module btgw_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_kind,
  output logic                    in_ready,
  input  wire btgw_pkg::status_t  status,
  output btgw_pkg::cmd_t          cmd
);

  btgw_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= btgw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      btgw_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == btgw_pkg::REQ_BEACON || !status.locked) begin
            state_next = btgw_pkg::ST_EMIT;
          end else begin
            state_next = btgw_pkg::ST_CHECK;
          end
        end
      end
      btgw_pkg::ST_CHECK: begin
        priority if (status.after && status.limit) begin
          state_next = btgw_pkg::ST_EMIT;
        end else if (status.after) begin
          state_next = btgw_pkg::ST_CHECK;
        end else begin
          state_next = btgw_pkg::ST_WINDOW;
        end
      end
      btgw_pkg::ST_WINDOW: begin
        state_next = btgw_pkg::ST_EMIT;
      end
      btgw_pkg::ST_EMIT: begin
        if (status.out_free) begin
          state_next = btgw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = btgw_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      btgw_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      btgw_pkg::ST_CHECK: begin
        cmd.step = 1'b1;
      end
      btgw_pkg::ST_WINDOW: begin
        cmd.window = 1'b1;
      end
      btgw_pkg::ST_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/btgw_dp.sv
// btgw_dp: prediction, miss count, lock flag, comparators and output register.
// Depends on btgw_pkg; driven by btgw_ctrl commands.
`default_nettype none

module btgw_dp #(
  parameter int unsigned MAX_MISSES = 3
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire btgw_pkg::cmd_t                cmd,
  output btgw_pkg::status_t                  status,
  input  wire logic                          in_kind,
  input  wire logic [btgw_pkg::TIME_W-1:0]   in_time,
  input  wire logic [btgw_pkg::TIME_W-1:0]   beacon_period,
  input  wire logic [btgw_pkg::TIME_W-1:0]   guard_time,
  input  wire logic [btgw_pkg::TIME_W-1:0]   occupancy_time,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [btgw_pkg::OUT_W-1:0]         out_data
);

  localparam logic [btgw_pkg::MISS_W-1:0] MaxMiss = btgw_pkg::MISS_W'(MAX_MISSES);

  logic [btgw_pkg::TIME_W-1:0] pred;
  logic [btgw_pkg::MISS_W-1:0] miss;
  logic                        lock;
  logic                        allowed;
  logic [btgw_pkg::TIME_W-1:0] query_time;
  logic [btgw_pkg::TIME_W-1:0] win_len;

  logic [btgw_pkg::TIME_W-1:0] win_end;
  logic [btgw_pkg::TIME_W-1:0] end_diff;
  logic [btgw_pkg::TIME_W-1:0] guard_diff;
  logic                        after;
  logic                        limit;

  // wrapping compares: sign of the 32-bit difference
  assign win_end    = pred + win_len;
  assign end_diff   = query_time - win_end;
  assign after      = (end_diff != '0) && !end_diff[btgw_pkg::TIME_W-1];
  assign guard_diff = query_time - (pred - guard_time);
  assign limit      = (miss >= MaxMiss);

  assign status.locked   = lock;
  assign status.after    = after;
  assign status.limit    = limit;
  assign status.out_free = !out_valid || out_ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pred <= '0;
      miss <= '0;
      lock <= 1'b0;
    end else begin
      priority if (cmd.load && in_kind == btgw_pkg::REQ_BEACON) begin
        pred <= in_time + beacon_period;
        miss <= '0;
        lock <= 1'b1;
      end else if (cmd.step && after) begin
        if (limit) begin
          lock <= 1'b0;
        end else begin
          miss <= miss + 1'b1;
          pred <= pred + beacon_period;
        end
      end
    end
  end

  // per-word working registers
  always_ff @(posedge clk) begin
    priority if (cmd.load) begin
      query_time <= in_time;
      win_len    <= occupancy_time + guard_time;
      allowed    <= 1'b1;
    end else if (cmd.step && after && limit) begin
      allowed <= 1'b1;
    end else if (cmd.window) begin
      allowed <= guard_diff[btgw_pkg::TIME_W-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= {(btgw_pkg::OUT_W - btgw_pkg::MISS_W - btgw_pkg::TIME_W - 2)'(0),
                   miss, pred, lock, allowed};
    end
  end

  a_miss_bounded: assert property (@(posedge clk) disable iff (rst)
    miss <= MaxMiss)
    else $error("miss count above limit");

  a_beacon_locks: assert property (@(posedge clk) disable iff (rst)
    cmd.load && in_kind == btgw_pkg::REQ_BEACON |=> lock && miss == '0)
    else $error("beacon did not lock");

  a_limit_unlocks: assert property (@(posedge clk) disable iff (rst)
    cmd.step && after && limit |=> !lock && allowed)
    else $error("miss limit did not unlock");

  a_emit_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> !$past(cmd.emit))
    else $error("output word overwritten");

endmodule

`default_nettype wire

FILE: src/beacon_tx_guard_window.sv
// beacon_tx_guard_window: top level, APB config registers, sequencer and datapath.
// Path: a beacon or unlocked query goes from accept straight to emit; a locked query runs
// catch-up steps (at most MAX_MISSES prediction advances), one superframe step per cycle,
// then the window compare; a query that hits the miss limit unlocks and skips the window.
// Throughput: one word in flight; next word accepted once the result is in the output reg.
// Reset (rst, sync): unlocked, prediction and miss count zero, registers zero, no output.
`default_nettype none

module beacon_tx_guard_window #(
  parameter int unsigned MAX_MISSES = 3
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // input stream
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [btgw_pkg::TIME_W-1:0]     s_tdata,   // [31:0] event_time
  input  wire logic                            s_tuser,   // [0] req_type
  // result stream
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [0] tx_allowed, [1] is_locked, [33:2] next_beacon_time, [41:34] miss_count,
  // [47:42] zero
  output logic [btgw_pkg::OUT_W-1:0]           m_tdata,
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [btgw_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [btgw_pkg::CFG_W-1:0]      pwdata,
  output logic [btgw_pkg::CFG_W-1:0]           prdata,
  output logic                                 pready
);

  logic [btgw_pkg::TIME_W-1:0] beacon_period;
  logic [btgw_pkg::TIME_W-1:0] guard_time;
  logic [btgw_pkg::TIME_W-1:0] occupancy_time;
  logic                        cfg_write;

  btgw_pkg::cmd_t    cmd;
  btgw_pkg::status_t status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // config registers; index from paddr[3:2], index 3 is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      beacon_period  <= '0;
      guard_time     <= '0;
      occupancy_time <= '0;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        btgw_pkg::REG_PERIOD: beacon_period  <= pwdata;
        btgw_pkg::REG_GUARD:  guard_time     <= pwdata;
        btgw_pkg::REG_OCC:    occupancy_time <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      btgw_pkg::REG_PERIOD: prdata = beacon_period;
      btgw_pkg::REG_GUARD:  prdata = guard_time;
      btgw_pkg::REG_OCC:    prdata = occupancy_time;
      default:              prdata = '0;
    endcase
  end

  // sequencer: idle -> (catch-up steps) -> (window compare) -> emit
  btgw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // prediction state, wrapping compares, output register
  btgw_dp #(
    .MAX_MISSES (MAX_MISSES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .in_kind        (s_tuser),
    .in_time        (s_tdata),
    .beacon_period  (beacon_period),
    .guard_time     (guard_time),
    .occupancy_time (occupancy_time),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_data       (m_tdata)
  );

endmodule

`default_nettype wire
